[rtl/akit_pkg.sv]
// ----------------------------------------------------------------------------
// akit_pkg: shared types and constants for the array key interning table
// Key layout, hash mixing constants and result field widths used by the
// front hash pipeline, the probe engine and the top level.
// ----------------------------------------------------------------------------
package akit_pkg;

   // Field widths of one key and of one result
   localparam int TYPE_W = 64;
   localparam int LEN_W  = 64;
   localparam int ID_W   = 10;

   // Hash mixing constants
   localparam logic [63:0] MIX_MUL_A   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_B   = 64'hff51afd7ed558ccd;
   localparam int          MIX_SHIFT_A = 33;
   localparam int          MIX_SHIFT_B = 29;
   localparam int          FLAG_SHIFT  = 56;

   // One stored key, compared as raw bits
   typedef struct packed {
      logic [TYPE_W-1:0] element_type;
      logic [LEN_W-1:0]  array_length;
      logic              static_flag;
      logic              incomplete_flag;
   } key_type;

   localparam int KEY_W = $bits(key_type);

endpackage

[rtl/akit_req_if.sv]
// ----------------------------------------------------------------------------
// akit_req_if: key request channel
// Valid/ready channel that carries one array key per transaction.
// ----------------------------------------------------------------------------
interface akit_req_if;
   logic                        valid;
   logic                        ready;
   logic [akit_pkg::TYPE_W-1:0] element_type;
   logic [akit_pkg::LEN_W-1:0]  array_length;
   logic                        static_flag;
   logic                        incomplete_flag;

   modport source (
      output valid, element_type, array_length, static_flag, incomplete_flag,
      input  ready
   );

   modport sink (
      input  valid, element_type, array_length, static_flag, incomplete_flag,
      output ready
   );
endinterface

[rtl/akit_rsp_if.sv]
// ----------------------------------------------------------------------------
// akit_rsp_if: intern result channel
// Valid/ready channel that carries one entry id and its status per
// transaction.
// ----------------------------------------------------------------------------
interface akit_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [akit_pkg::ID_W-1:0] entry_id;
   logic                      newly_added;
   logic                      table_full;

   modport source (
      output valid, entry_id, newly_added, table_full,
      input  ready
   );

   modport sink (
      input  valid, entry_id, newly_added, table_full,
      output ready
   );
endinterface

[rtl/akit_front.sv]
// ----------------------------------------------------------------------------
// akit_front: key hash pipeline
// Accepts keys and computes the home slot of each through a five stage
// pipeline of 32x32 partial products and mixing steps, then hands the key
// and its home slot to the probe queue.
// ----------------------------------------------------------------------------
module akit_front #(
   parameter  int CAPACITY = 1024,
   localparam int SLOT_AW  = $clog2(2 * CAPACITY)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clearing,
   akit_req_if.sink             req_bus,
   input  logic                 q_ready,
   output logic                 q_valid,
   output akit_pkg::key_type    q_key,
   output logic [SLOT_AW-1:0]   q_home
);

   localparam int STAGES     = 5;
   localparam int SLOT_COUNT = 2 * CAPACITY;
   localparam int PROD_W     = 32 + SLOT_AW + 1;
   localparam logic [SLOT_AW:0] SLOT_COUNT_V = (SLOT_AW + 1)'(SLOT_COUNT);

   logic [STAGES-1:0] stage_valid_ff;
   logic [STAGES-1:0] stage_valid_in;
   logic [STAGES-1:0] advance;
   logic              accept;

   akit_pkg::key_type key_in_w;
   akit_pkg::key_type key1_ff, key2_ff, key3_ff, key4_ff, key5_ff;

   logic [63:0]        p0_ff;
   logic [31:0]        p1_ff, p2_ff;
   logic [63:0]        x2_ff;
   logic [63:0]        q0_ff;
   logic [31:0]        q1_ff, q2_ff;
   logic [31:0]        g4_ff;
   logic [SLOT_AW-1:0] home5_ff;

   logic [31:0]       hi_sum_a, hi_sum_b;
   logic [63:0]       h_a, mixed_a, x_a;
   logic [63:0]       flag_word;
   logic [63:0]       y_b, z_b;
   logic [PROD_W-1:0] home_prod;

   // Advance each stage when it is empty or its successor advances
   always_comb begin
      advance[STAGES-1] = !stage_valid_ff[STAGES-1] || q_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         advance[k] = !stage_valid_ff[k] || advance[k+1];
      end
   end

   assign req_bus.ready = advance[0] && !clearing;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      stage_valid_in[0] = advance[0] ? accept : stage_valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         stage_valid_in[k] = advance[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Gather the incoming key
   always_comb begin
      key_in_w.element_type    = req_bus.element_type;
      key_in_w.array_length    = req_bus.array_length;
      key_in_w.static_flag     = req_bus.static_flag;
      key_in_w.incomplete_flag = req_bus.incomplete_flag;
   end

   // Stage 1: partial products of element times the first constant
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         key1_ff <= key_in_w;
         p0_ff   <= {32'b0, key_in_w.element_type[31:0]} *
                    {32'b0, akit_pkg::MIX_MUL_A[31:0]};
         p1_ff   <= key_in_w.element_type[31:0] * akit_pkg::MIX_MUL_A[63:32];
         p2_ff   <= key_in_w.element_type[63:32] * akit_pkg::MIX_MUL_A[31:0];
      end
   end

   // Stage 2: combine products, fold in length and flags, first shift mix
   always_comb begin
      hi_sum_a  = p1_ff + p2_ff;
      h_a       = p0_ff + {hi_sum_a, 32'b0};
      flag_word = {62'b0, key1_ff.incomplete_flag, key1_ff.static_flag};
      mixed_a   = h_a ^ key1_ff.array_length ^ (flag_word << akit_pkg::FLAG_SHIFT);
      x_a       = mixed_a ^ (mixed_a >> akit_pkg::MIX_SHIFT_A);
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         key2_ff <= key1_ff;
         x2_ff   <= x_a;
      end
   end

   // Stage 3: partial products with the second constant
   always_ff @(posedge clock) begin
      if (advance[2]) begin
         key3_ff <= key2_ff;
         q0_ff   <= {32'b0, x2_ff[31:0]} * {32'b0, akit_pkg::MIX_MUL_B[31:0]};
         q1_ff   <= x2_ff[31:0] * akit_pkg::MIX_MUL_B[63:32];
         q2_ff   <= x2_ff[63:32] * akit_pkg::MIX_MUL_B[31:0];
      end
   end

   // Stage 4: combine products, second shift mix, keep the upper word
   always_comb begin
      hi_sum_b = q1_ff + q2_ff;
      y_b      = q0_ff + {hi_sum_b, 32'b0};
      z_b      = y_b ^ (y_b >> akit_pkg::MIX_SHIFT_B);
   end

   always_ff @(posedge clock) begin
      if (advance[3]) begin
         key4_ff <= key3_ff;
         g4_ff   <= z_b[63:32];
      end
   end

   // Stage 5: scale the hash onto the slot range
   assign home_prod = PROD_W'(g4_ff) * PROD_W'(SLOT_COUNT_V);

   always_ff @(posedge clock) begin
      if (advance[4]) begin
         key5_ff  <= key4_ff;
         home5_ff <= home_prod[32 +: SLOT_AW];
      end
   end

   assign q_valid = stage_valid_ff[STAGES-1];
   assign q_key   = key5_ff;
   assign q_home  = home5_ff;

endmodule

[rtl/akit_queue.sv]
// ----------------------------------------------------------------------------
// akit_queue: hashed key queue
// Small register FIFO between the hash pipeline and the probe engine so
// that each side stalls on its own.
// ----------------------------------------------------------------------------
module akit_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Advance pointers and track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[rtl/akit_back.sv]
// ----------------------------------------------------------------------------
// akit_back: probe and insert engine
// Clears the slot table after reset, then takes hashed keys one at a time,
// probes the slot table linearly from the home slot, compares stored keys,
// appends new keys and delivers one result per key.
// ----------------------------------------------------------------------------
module akit_back #(
   parameter  int CAPACITY = 1024,
   localparam int SLOT_AW  = $clog2(2 * CAPACITY)
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clearing,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  akit_pkg::key_type    q_key,
   input  logic [SLOT_AW-1:0]   q_home,
   akit_rsp_if.source           rsp_bus
);

   localparam int SLOT_COUNT = 2 * CAPACITY;
   localparam int ENT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int ID_W       = akit_pkg::ID_W;
   localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SLOT_COUNT - 1);
   localparam logic [ENT_W-1:0]   CAP_V     = ENT_W'(CAPACITY);
   localparam logic [ENT_W-1:0]   ENT_ONE   = ENT_W'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT,
      ST_KEY,
      ST_DELIVER
   } state_type;

   // Slot table and key store
   logic [ENT_W-1:0]  slot_mem [SLOT_COUNT];
   akit_pkg::key_type key_mem  [CAPACITY];

   logic [ENT_W-1:0]  slot_rd_ff;
   akit_pkg::key_type key_rd_ff;

   logic               slot_we, slot_re;
   logic [SLOT_AW-1:0] slot_addr;
   logic [ENT_W-1:0]   slot_wdata;
   logic               key_we, key_re;
   logic [IDX_W-1:0]   key_waddr, key_raddr;

   // Engine state
   state_type          state_ff, state_in;
   logic [SLOT_AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [ENT_W-1:0]   count_ff, count_in;
   akit_pkg::key_type  key_ff, key_in;
   logic [SLOT_AW-1:0] slot_ff, slot_in;
   logic [ENT_W-1:0]   ent_ff, ent_in;
   logic [ENT_W-1:0]   res_id_ff, res_id_in;
   logic               res_added_ff, res_added_in;
   logic               res_full_ff, res_full_in;

   // Registered result port
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_added_ff, rsp_added_in;
   logic              rsp_full_ff, rsp_full_in;

   logic [ENT_W-1:0]      ent_minus;
   logic [SLOT_AW-1:0]    slot_next;
   logic [ENT_W+ID_W-1:0] id_wide;
   logic                  out_free;

   assign ent_minus = slot_rd_ff - ENT_ONE;
   assign slot_next = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_AW'(1);
   assign id_wide   = {{ID_W{1'b0}}, res_id_ff};
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // Slot table port: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_addr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_addr];
      end
   end

   // Key store port
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_raddr];
      end
   end

   // Sequence the clearing pass, the probe walk and result delivery
   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      ent_in       = ent_ff;
      res_id_in    = res_id_ff;
      res_added_in = res_added_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_added_in = rsp_added_ff;
      rsp_full_in  = rsp_full_ff;
      slot_we      = 1'b0;
      slot_re      = 1'b0;
      slot_addr    = slot_ff;
      slot_wdata   = '0;
      key_we       = 1'b0;
      key_re       = 1'b0;
      key_waddr    = count_ff[IDX_W-1:0];
      key_raddr    = ent_minus[IDX_W-1:0];
      q_ready      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_addr  = clr_ptr_ff;
            slot_wdata = '0;
            clr_ptr_in = clr_ptr_ff + SLOT_AW'(1);
            if (clr_ptr_ff == SLOT_LAST) begin
               clr_ptr_in = '0;
               state_in   = ST_IDLE;
            end
         end

         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               key_in    = q_key;
               slot_in   = q_home;
               slot_re   = 1'b1;
               slot_addr = q_home;
               state_in  = ST_SLOT;
            end
         end

         ST_SLOT: begin
            if (slot_rd_ff == '0 || slot_rd_ff > CAP_V) begin
               // Empty slot: append the key or report a full store
               if (count_ff >= CAP_V) begin
                  res_id_in    = '0;
                  res_added_in = 1'b0;
                  res_full_in  = 1'b1;
               end else begin
                  key_we       = 1'b1;
                  slot_we      = 1'b1;
                  slot_addr    = slot_ff;
                  slot_wdata   = count_ff + ENT_ONE;
                  count_in     = count_ff + ENT_ONE;
                  res_id_in    = count_ff;
                  res_added_in = 1'b1;
                  res_full_in  = 1'b0;
               end
               state_in = ST_DELIVER;
            end else begin
               key_re   = 1'b1;
               ent_in   = slot_rd_ff;
               state_in = ST_KEY;
            end
         end

         ST_KEY: begin
            if (key_rd_ff == key_ff) begin
               res_id_in    = ent_ff - ENT_ONE;
               res_added_in = 1'b0;
               res_full_in  = 1'b0;
               state_in     = ST_DELIVER;
            end else begin
               // Mismatch: step to the next slot with wrap
               slot_in   = slot_next;
               slot_re   = 1'b1;
               slot_addr = slot_next;
               state_in  = ST_SLOT;
            end
         end

         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_wide[ID_W-1:0];
               rsp_added_in = res_added_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      slot_ff      <= slot_in;
      ent_ff       <= ent_in;
      res_id_ff    <= res_id_in;
      res_added_ff <= res_added_in;
      res_full_ff  <= res_full_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_added_ff <= rsp_added_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign clearing            = (state_ff == ST_CLEAR);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.entry_id    = rsp_id_ff;
   assign rsp_bus.newly_added = rsp_added_ff;
   assign rsp_bus.table_full  = rsp_full_ff;

endmodule

[rtl/array_key_interning_table.sv]
// ----------------------------------------------------------------------------
// array_key_interning_table: hash consing table for array type keys
// Hash pipeline, key queue and probe engine with linear probing.
// ----------------------------------------------------------------------------
// After reset the block clears its 2*CAPACITY-entry slot table, one slot per
// cycle, and accepts no key until the clearing pass is done. Each key then
// runs through the hash pipeline into a two entry queue; the probe engine
// takes one key at a time and walks linearly from the home slot: it reads
// the slot table, ends with a new key at an empty slot, else reads the key
// store and ends with the stored id on a match or steps to the next slot.
// Ids count up from 0 in order of first appearance; once CAPACITY keys are
// held, a new key returns table_full with entry_id 0 while known keys are
// still found. The hash pipeline keeps accepting keys while the engine
// probes and while a result waits on rsp, until it and the queue are full.
// ----------------------------------------------------------------------------
module array_key_interning_table #(
   parameter int CAPACITY = 1024
) (
   input logic        clock,
   input logic        reset,
   akit_req_if.sink   req_bus,
   akit_rsp_if.source rsp_bus
);

   localparam int SLOT_AW     = $clog2(2 * CAPACITY);
   localparam int QUEUE_W     = akit_pkg::KEY_W + SLOT_AW;
   localparam int QUEUE_DEPTH = 2;

   logic               clearing;
   logic               front_valid, front_ready;
   akit_pkg::key_type  front_key;
   logic [SLOT_AW-1:0] front_home;
   logic               back_valid, back_ready;
   logic [QUEUE_W-1:0] back_data;
   akit_pkg::key_type  back_key;
   logic [SLOT_AW-1:0] back_home;

   akit_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .req_bus  (req_bus),
      .q_ready  (front_ready),
      .q_valid  (front_valid),
      .q_key    (front_key),
      .q_home   (front_home)
   );

   akit_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   ({front_key, front_home}),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   // Split the queued entry back into key and home slot
   assign back_key  = back_data[QUEUE_W-1 -: akit_pkg::KEY_W];
   assign back_home = back_data[SLOT_AW-1:0];

   akit_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .q_valid  (back_valid),
      .q_ready  (back_ready),
      .q_key    (back_key),
      .q_home   (back_home),
      .rsp_bus  (rsp_bus)
   );

endmodule

[sim/tb_array_key_interning_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_key_interning_table: self-checking bench for the key interning table
// A directed table covers field extremes, flag-only differences and repeated
// keys. Random keys then fill the store to capacity and keep going past it.
// Typed directed rows are checked against their listed results, all others
// against a local mirror of the slot table and the key store, with random
// gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_array_key_interning_table;

   localparam int          CAPACITY    = 1024;
   localparam int          SLOTS       = 2 * CAPACITY;
   localparam int          ID_W        = akit_pkg::ID_W;
   localparam int          KEY_W       = akit_pkg::KEY_W;
   localparam int          PERIOD      = 20;
   localparam int          DRAIN       = 100;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          FILL_LIMIT  = 1500;
   localparam int          OVER_ITEMS  = 150;
   localparam int          BURST_RUN   = 40;
   localparam logic [63:0] ONES        = '1;
   localparam logic [63:0] MSB         = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALT_A       = 64'h5555_5555_5555_5555;
   localparam logic [63:0] ALT_B       = 64'haaaa_aaaa_aaaa_aaaa;

   typedef struct packed {
      logic [ID_W-1:0] entry_id;
      logic            newly_added;
      logic            table_full;
   } intern_result_type;

   typedef struct packed {
      akit_pkg::key_type key;
      logic              typed;
      intern_result_type want;
   } stim_row_type;

   localparam int DIRECTED_N = 21;
   localparam stim_row_type DIRECTED [DIRECTED_N] = '{
      '{'{64'h0,  64'h0,  1'b0, 1'b0}, 1'b1, '{10'd0,  1'b1, 1'b0}},
      '{'{ONES,   ONES,   1'b1, 1'b1}, 1'b1, '{10'd1,  1'b1, 1'b0}},
      '{'{64'h0,  64'h0,  1'b0, 1'b0}, 1'b1, '{10'd0,  1'b0, 1'b0}},
      '{'{64'h0,  64'h0,  1'b1, 1'b0}, 1'b1, '{10'd2,  1'b1, 1'b0}},
      '{'{64'h0,  64'h0,  1'b0, 1'b1}, 1'b1, '{10'd3,  1'b1, 1'b0}},
      '{'{64'h0,  64'h0,  1'b1, 1'b1}, 1'b1, '{10'd4,  1'b1, 1'b0}},
      '{'{ONES,   ONES,   1'b1, 1'b1}, 1'b1, '{10'd1,  1'b0, 1'b0}},
      '{'{MSB,    64'h1,  1'b0, 1'b0}, 1'b1, '{10'd5,  1'b1, 1'b0}},
      '{'{64'h1,  MSB,    1'b0, 1'b0}, 1'b1, '{10'd6,  1'b1, 1'b0}},
      '{'{MSB,    64'h1,  1'b0, 1'b0}, 1'b1, '{10'd5,  1'b0, 1'b0}},
      '{'{64'h0,  64'h1,  1'b0, 1'b0}, 1'b1, '{10'd7,  1'b1, 1'b0}},
      '{'{64'h1,  64'h0,  1'b0, 1'b0}, 1'b1, '{10'd8,  1'b1, 1'b0}},
      '{'{ONES,   64'h0,  1'b0, 1'b0}, 1'b1, '{10'd9,  1'b1, 1'b0}},
      '{'{64'h0,  ONES,   1'b0, 1'b0}, 1'b1, '{10'd10, 1'b1, 1'b0}},
      '{'{ALT_A,  ALT_B,  1'b1, 1'b0}, 1'b1, '{10'd11, 1'b1, 1'b0}},
      '{'{ALT_B,  ALT_A,  1'b0, 1'b1}, 1'b1, '{10'd12, 1'b1, 1'b0}},
      '{'{ALT_A,  ALT_B,  1'b1, 1'b0}, 1'b1, '{10'd11, 1'b0, 1'b0}},
      '{'{ONES,   ONES,   1'b0, 1'b0}, 1'b0, '{10'd0,  1'b0, 1'b0}},
      '{'{ONES,   ONES,   1'b0, 1'b1}, 1'b0, '{10'd0,  1'b0, 1'b0}},
      '{'{64'h0,  64'h0,  1'b1, 1'b1}, 1'b0, '{10'd0,  1'b0, 1'b0}},
      '{'{ALT_B,  ALT_A,  1'b0, 1'b1}, 1'b0, '{10'd0,  1'b0, 1'b0}}
   };

   logic clock;
   logic reset;

   akit_req_if req_bus ();
   akit_rsp_if rsp_bus ();

   array_key_interning_table #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Mirror of the table state
   akit_pkg::key_type mirror_keys  [CAPACITY];
   int unsigned       mirror_slots [SLOTS];
   int unsigned       mirror_count;

   intern_result_type pending_results [$];
   akit_pkg::key_type sent_keys [$];
   int                error_count;
   int                cycle_count;
   int                added_count;
   int                found_count;
   int                refused_count;
   int                checked_count;

   // Free-running clock
   always #(PERIOD / 2) clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Hash of one key down to 32 bits
   function automatic logic [31:0] mix_key_hash(akit_pkg::key_type k);
      logic [63:0] h;
      logic [63:0] fl;
      fl = {62'b0, k.incomplete_flag, k.static_flag};
      h  = k.element_type * akit_pkg::MIX_MUL_A;
      h  = h ^ k.array_length ^ (fl << akit_pkg::FLAG_SHIFT);
      h  = h ^ (h >> akit_pkg::MIX_SHIFT_A);
      h  = h * akit_pkg::MIX_MUL_B;
      h  = h ^ (h >> akit_pkg::MIX_SHIFT_B);
      return h[63:32];
   endfunction

   // Look the key up in the mirror, insert it on a miss while there is room, return the result
   function automatic intern_result_type predict_intern(akit_pkg::key_type k);
      intern_result_type res;
      logic [63:0]       scaled;
      int unsigned       slot;
      int unsigned       probes;
      int unsigned       e;
      bit                found;
      res    = '0;
      found  = 1'b0;
      scaled = {32'b0, mix_key_hash(k)} * 64'(SLOTS);
      slot   = int'(scaled >> 32);
      for (probes = 0; probes < SLOTS; probes++) begin
         e = mirror_slots[slot];
         if (e == 0 || e > CAPACITY) break;
         if (mirror_keys[e - 1] == k) begin
            res.entry_id = ID_W'(e - 1);
            found = 1'b1;
            break;
         end
         slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
      end
      if (found) begin
         found_count++;
      end else if (mirror_count >= CAPACITY) begin
         res.table_full = 1'b1;
         refused_count++;
      end else begin
         mirror_keys[mirror_count] = k;
         if (probes < SLOTS && mirror_slots[slot] == 0) mirror_slots[slot] = mirror_count + 1;
         res.entry_id    = ID_W'(mirror_count);
         res.newly_added = 1'b1;
         mirror_count++;
         added_count++;
      end
      return res;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : int'($urandom_range(0, 15));
   endfunction

   // Present one key after a gap; return at the falling edge after acceptance
   task automatic present_key(akit_pkg::key_type k, logic typed, intern_result_type want,
                              int gap);
      intern_result_type predicted;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.element_type    <= k.element_type;
      req_bus.array_length    <= k.array_length;
      req_bus.static_flag     <= k.static_flag;
      req_bus.incomplete_flag <= k.incomplete_flag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_intern(k);
      pending_results.push_back(typed ? want : predicted);
      sent_keys.push_back(k);
      @(negedge clock);
   endtask

   // Random key: wide values, or small ones that crowd near each other
   function automatic akit_pkg::key_type random_key();
      akit_pkg::key_type k;
      if ($urandom_range(0, 3) == 0) begin
         k.element_type = 64'($urandom_range(0, 7));
         k.array_length = 64'($urandom_range(0, 7));
      end else begin
         k.element_type = {$urandom, $urandom};
         k.array_length = {$urandom, $urandom};
      end
      k.static_flag     = 1'($urandom);
      k.incomplete_flag = 1'($urandom);
      return k;
   endfunction

   // Stimulus
   initial begin : stimulus
      akit_pkg::key_type   k;
      logic [KEY_W-1:0]    flip;
      int                  i;
      int                  sent;
      bit                  burst;
      clock                   = 1'b0;
      reset                   = 1'b1;
      cycle_count             = 0;
      error_count             = 0;
      added_count             = 0;
      found_count             = 0;
      refused_count           = 0;
      checked_count           = 0;
      mirror_count            = 0;
      burst                   = 1'b0;
      req_bus.valid           = 1'b0;
      req_bus.element_type    = '0;
      req_bus.array_length    = '0;
      req_bus.static_flag     = 1'b0;
      req_bus.incomplete_flag = 1'b0;
      foreach (mirror_slots[s]) mirror_slots[s] = 0;
      foreach (mirror_keys[s]) mirror_keys[s] = '0;

      // Hold reset, release it away from the active edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (i = 0; i < DIRECTED_N; i++) begin
         present_key(DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].want,
                     draw_wait(i < 8));
      end

      // Fill the store: mostly new keys, some repeats and one-bit neighbors
      sent = 0;
      while (mirror_count < CAPACITY && sent < FILL_LIMIT) begin
         if (sent % BURST_RUN == 0) burst = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
            1, 2: begin
               flip = '0;
               flip[$urandom_range(0, KEY_W - 1)] = 1'b1;
               k = akit_pkg::key_type'(sent_keys[$urandom_range(0, sent_keys.size() - 1)]
                                       ^ flip);
            end
            default: k = random_key();
         endcase
         present_key(k, 1'b0, '0, draw_wait(burst));
         sent++;
      end

      // Past capacity: known keys still found, new keys refused
      for (i = 0; i < OVER_ITEMS; i++) begin
         if (i % BURST_RUN == 0) burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 0) k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
         else k = random_key();
         present_key(k, 1'b0, '0, draw_wait(burst));
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("tb: %0d results checked; %0d keys inserted, %0d found again,",
               checked_count, added_count, found_count);
      $display("tb: %0d refused with the store full (capacity %0d)", refused_count, CAPACITY);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Result side: random stalls, check each transaction in order
   initial begin : result_sink
      intern_result_type want;
      int                stall;
      int                taken;
      bit                burst;
      rsp_bus.ready = 1'b0;
      taken         = 0;
      burst         = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (taken % BURST_RUN == 0) burst = ($urandom_range(0, 3) == 0);
         stall = draw_wait(burst);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         taken++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: entry_id %0d, newly_added %0b, table_full %0b",
                   rsp_bus.entry_id, rsp_bus.newly_added, rsp_bus.table_full);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_bus.entry_id !== want.entry_id) begin
               $error("entry_id: expected %0d, actual %0d", want.entry_id, rsp_bus.entry_id);
               error_count++;
            end
            if (rsp_bus.newly_added !== want.newly_added) begin
               $error("newly_added: expected %0b, actual %0b",
                      want.newly_added, rsp_bus.newly_added);
               error_count++;
            end
            if (rsp_bus.table_full !== want.table_full) begin
               $error("table_full: expected %0b, actual %0b",
                      want.table_full, rsp_bus.table_full);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

endmodule

[sim.f]
rtl/akit_pkg.sv
rtl/akit_req_if.sv
rtl/akit_rsp_if.sv
rtl/akit_front.sv
rtl/akit_queue.sv
rtl/akit_back.sv
rtl/array_key_interning_table.sv
sim/tb_array_key_interning_table.sv
